@@ rtl/jsu_pkg.sv @@
// jsu_pkg: shared types and character codes for the json string unescape block
// depends on nothing; used by jsu_decode, jsu_serializer and the top level
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_STR,
    PH_ESC,
    PH_HEX,
    PH_LOW
  } phase_t;

  typedef enum logic [3:0] {
    ST_BYTE       = 4'd0,
    ST_DONE       = 4'd1,
    ST_QUOTE      = 4'd2,
    ST_CTRL       = 4'd3,
    ST_END_ESC    = 4'd4,
    ST_BAD_ESC    = 4'd5,
    ST_INCOMPLETE = 4'd6,
    ST_BAD_HEX    = 4'd7,
    ST_MISS_LOW   = 4'd8,
    ST_BAD_LOW    = 4'd9,
    ST_STRAY_LOW  = 4'd10,
    ST_UNTERM     = 4'd11
  } status_t;

  // results caused by one source byte: up to four utf-8 bytes or one status
  typedef struct packed {
    logic [2:0]       count;
    status_t          status;
    logic [3:0][7:0]  bytes;
  } res_group_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LC_B = 8'h62;
  localparam logic [7:0] CH_LC_F = 8'h66;
  localparam logic [7:0] CH_LC_N = 8'h6E;
  localparam logic [7:0] CH_LC_R = 8'h72;
  localparam logic [7:0] CH_LC_T = 8'h74;
  localparam logic [7:0] CH_LC_U = 8'h75;
  localparam logic [7:0] CH_BS = 8'h08;
  localparam logic [7:0] CH_FF = 8'h0C;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam logic [15:0] HIGH_SURR_MIN = 16'hD800;
  localparam logic [15:0] HIGH_SURR_MAX = 16'hDBFF;
  localparam logic [15:0] LOW_SURR_MIN = 16'hDC00;
  localparam logic [15:0] LOW_SURR_MAX = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  localparam logic [2:0] QUAD_CHARS = 3'd4;
  localparam logic [2:0] LOW_ESC_CHARS = 3'd6;

endpackage

`default_nettype wire

@@ rtl/jsu_decode.sv @@
// jsu_decode: parser state registers and the per-byte decode into a result group
// depends on jsu_pkg
`timescale 1ns / 1ps
`default_nettype none

module jsu_decode (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire logic [7:0]        data_byte,
  input  wire logic              end_of_input,
  output jsu_pkg::res_group_t    res
);

  jsu_pkg::phase_t  phase, phase_next;
  logic [15:0]      hex_acc, hex_acc_next;
  logic [2:0]       digit_count, digit_count_next;
  logic [9:0]       high_bits, high_bits_next;
  jsu_pkg::status_t pending, pending_next;

  logic             is_ws;
  logic             hex_bad;
  logic [3:0]       hex_digit;
  logic             gather_on;
  jsu_pkg::status_t pend_g;
  logic [15:0]      acc_g;
  logic [2:0]       cnt_g;
  logic             quad_done;
  logic             low_done;
  logic             is_high;
  logic             is_low;
  logic [20:0]      cp_pair;
  logic             abort;

  function automatic jsu_pkg::res_group_t utf8_enc(input logic [20:0] cp);
    jsu_pkg::res_group_t g;
    g = '0;
    g.status = jsu_pkg::ST_BYTE;
    if (cp <= 21'h7F) begin
      g.count = 3'd1;
      g.bytes[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      g.count = 3'd2;
      g.bytes[0] = {3'b110, cp[10:6]};
      g.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      g.count = 3'd3;
      g.bytes[0] = {4'b1110, cp[15:12]};
      g.bytes[1] = {2'b10, cp[11:6]};
      g.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      g.count = 3'd4;
      g.bytes[0] = {5'b11110, cp[20:18]};
      g.bytes[1] = {2'b10, cp[17:12]};
      g.bytes[2] = {2'b10, cp[11:6]};
      g.bytes[3] = {2'b10, cp[5:0]};
    end
    return g;
  endfunction

  function automatic jsu_pkg::res_group_t one_result(input jsu_pkg::status_t st,
                                                     input logic [7:0] b);
    jsu_pkg::res_group_t g;
    g = '0;
    g.count = 3'd1;
    g.status = st;
    g.bytes[0] = (st == jsu_pkg::ST_BYTE) ? b : 8'h00;
    return g;
  endfunction

  assign is_ws = (data_byte == jsu_pkg::CH_SPACE) ||
                 ((data_byte >= jsu_pkg::CH_TAB) && (data_byte <= jsu_pkg::CH_CR));

  always_comb begin
    hex_bad = 1'b0;
    hex_digit = 4'd0;
    if (data_byte >= 8'h30 && data_byte <= 8'h39) begin
      hex_digit = data_byte[3:0];
    end else if ((data_byte >= 8'h61 && data_byte <= 8'h66) ||
                 (data_byte >= 8'h41 && data_byte <= 8'h46)) begin
      hex_digit = data_byte[3:0] + 4'd9;
    end else begin
      hex_bad = 1'b1;
    end
  end

  // the first two characters of a low escape are the backslash and the 'u'
  assign gather_on = (phase == jsu_pkg::PH_HEX) ||
                     ((phase == jsu_pkg::PH_LOW) && (digit_count[2:1] != 2'b00));

  always_comb begin
    pend_g = pending;
    if (phase == jsu_pkg::PH_LOW && digit_count == 3'd0) begin
      if (data_byte != jsu_pkg::CH_BSLASH) pend_g = jsu_pkg::ST_MISS_LOW;
    end else if (phase == jsu_pkg::PH_LOW && digit_count == 3'd1) begin
      if (data_byte != jsu_pkg::CH_LC_U) pend_g = jsu_pkg::ST_MISS_LOW;
    end else if (gather_on && hex_bad && pending == jsu_pkg::ST_BYTE) begin
      pend_g = jsu_pkg::ST_BAD_HEX;
    end
  end

  assign acc_g = gather_on ? {hex_acc[11:0], hex_digit} : hex_acc;
  assign cnt_g = digit_count + 3'd1;
  assign quad_done = (phase == jsu_pkg::PH_HEX) && (cnt_g == jsu_pkg::QUAD_CHARS);
  assign low_done = (phase == jsu_pkg::PH_LOW) && (cnt_g == jsu_pkg::LOW_ESC_CHARS);
  assign is_high = (acc_g >= jsu_pkg::HIGH_SURR_MIN) && (acc_g <= jsu_pkg::HIGH_SURR_MAX);
  assign is_low = (acc_g >= jsu_pkg::LOW_SURR_MIN) && (acc_g <= jsu_pkg::LOW_SURR_MAX);
  assign cp_pair = jsu_pkg::SUPP_BASE + {1'b0, high_bits, acc_g[9:0]};

  // result group and abort flag
  always_comb begin
    res = '0;
    res.status = jsu_pkg::ST_BYTE;
    abort = 1'b0;
    unique case (phase)
      jsu_pkg::PH_IDLE: begin
        if (end_of_input || (!is_ws && data_byte != jsu_pkg::CH_QUOTE)) begin
          res = one_result(jsu_pkg::ST_QUOTE, 8'h00);
        end
      end
      jsu_pkg::PH_STR: begin
        if (end_of_input) begin
          res = one_result(jsu_pkg::ST_UNTERM, 8'h00);
          abort = 1'b1;
        end else if (data_byte == jsu_pkg::CH_QUOTE) begin
          res = one_result(jsu_pkg::ST_DONE, 8'h00);
        end else if (data_byte == jsu_pkg::CH_BSLASH) begin
          res.count = 3'd0;
        end else if (data_byte < jsu_pkg::CH_SPACE) begin
          res = one_result(jsu_pkg::ST_CTRL, 8'h00);
          abort = 1'b1;
        end else begin
          res = one_result(jsu_pkg::ST_BYTE, data_byte);
        end
      end
      jsu_pkg::PH_ESC: begin
        if (end_of_input) begin
          res = one_result(jsu_pkg::ST_END_ESC, 8'h00);
          abort = 1'b1;
        end else begin
          unique case (data_byte)
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH:
              res = one_result(jsu_pkg::ST_BYTE, data_byte);
            jsu_pkg::CH_LC_B: res = one_result(jsu_pkg::ST_BYTE, jsu_pkg::CH_BS);
            jsu_pkg::CH_LC_F: res = one_result(jsu_pkg::ST_BYTE, jsu_pkg::CH_FF);
            jsu_pkg::CH_LC_N: res = one_result(jsu_pkg::ST_BYTE, jsu_pkg::CH_LF);
            jsu_pkg::CH_LC_R: res = one_result(jsu_pkg::ST_BYTE, jsu_pkg::CH_CR);
            jsu_pkg::CH_LC_T: res = one_result(jsu_pkg::ST_BYTE, jsu_pkg::CH_TAB);
            jsu_pkg::CH_LC_U: res.count = 3'd0;
            default: begin
              res = one_result(jsu_pkg::ST_BAD_ESC, 8'h00);
              abort = 1'b1;
            end
          endcase
        end
      end
      jsu_pkg::PH_HEX: begin
        if (end_of_input) begin
          res = one_result(jsu_pkg::ST_INCOMPLETE, 8'h00);
          abort = 1'b1;
        end else if (quad_done) begin
          if (pend_g != jsu_pkg::ST_BYTE) begin
            res = one_result(pend_g, 8'h00);
            abort = 1'b1;
          end else if (is_high) begin
            res.count = 3'd0;
          end else if (is_low) begin
            res = one_result(jsu_pkg::ST_STRAY_LOW, 8'h00);
            abort = 1'b1;
          end else begin
            res = utf8_enc({5'd0, acc_g});
          end
        end
      end
      jsu_pkg::PH_LOW: begin
        if (end_of_input) begin
          res = one_result(jsu_pkg::ST_MISS_LOW, 8'h00);
          abort = 1'b1;
        end else if (low_done) begin
          if (pend_g != jsu_pkg::ST_BYTE) begin
            res = one_result(pend_g, 8'h00);
            abort = 1'b1;
          end else if (!is_low) begin
            res = one_result(jsu_pkg::ST_BAD_LOW, 8'h00);
            abort = 1'b1;
          end else begin
            res = utf8_enc(cp_pair);
          end
        end
      end
      default: begin
        abort = 1'b1;
      end
    endcase
  end

  // next state
  always_comb begin
    phase_next = phase;
    hex_acc_next = hex_acc;
    digit_count_next = digit_count;
    high_bits_next = high_bits;
    pending_next = pending;
    if (abort) begin
      phase_next = jsu_pkg::PH_IDLE;
      hex_acc_next = '0;
      digit_count_next = '0;
      high_bits_next = '0;
      pending_next = jsu_pkg::ST_BYTE;
    end else if (!end_of_input) begin
      unique case (phase)
        jsu_pkg::PH_IDLE: begin
          if (data_byte == jsu_pkg::CH_QUOTE) phase_next = jsu_pkg::PH_STR;
        end
        jsu_pkg::PH_STR: begin
          if (data_byte == jsu_pkg::CH_QUOTE) phase_next = jsu_pkg::PH_IDLE;
          else if (data_byte == jsu_pkg::CH_BSLASH) phase_next = jsu_pkg::PH_ESC;
        end
        jsu_pkg::PH_ESC: begin
          if (data_byte == jsu_pkg::CH_LC_U) begin
            phase_next = jsu_pkg::PH_HEX;
            hex_acc_next = '0;
            digit_count_next = '0;
            pending_next = jsu_pkg::ST_BYTE;
          end else begin
            phase_next = jsu_pkg::PH_STR;
          end
        end
        jsu_pkg::PH_HEX: begin
          hex_acc_next = acc_g;
          digit_count_next = cnt_g;
          pending_next = pend_g;
          if (quad_done) begin
            hex_acc_next = '0;
            digit_count_next = '0;
            if (is_high) begin
              phase_next = jsu_pkg::PH_LOW;
              high_bits_next = acc_g[9:0];
            end else begin
              phase_next = jsu_pkg::PH_STR;
            end
          end
        end
        jsu_pkg::PH_LOW: begin
          hex_acc_next = acc_g;
          digit_count_next = cnt_g;
          pending_next = pend_g;
          if (low_done) begin
            phase_next = jsu_pkg::PH_STR;
            hex_acc_next = '0;
            digit_count_next = '0;
            high_bits_next = '0;
          end
        end
        default: begin
          phase_next = jsu_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= jsu_pkg::PH_IDLE;
      hex_acc <= '0;
      digit_count <= '0;
      high_bits <= '0;
      pending <= jsu_pkg::ST_BYTE;
    end else if (fire) begin
      phase <= phase_next;
      hex_acc <= hex_acc_next;
      digit_count <= digit_count_next;
      high_bits <= high_bits_next;
      pending <= pending_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/jsu_serializer.sv @@
// jsu_serializer: result group register, hands out its results one per transaction
// depends on jsu_pkg
`timescale 1ns / 1ps
`default_nettype none

module jsu_serializer (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                load,
  input  wire jsu_pkg::res_group_t res,
  output logic                     free,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [7:0]               m_tdata,   // out_byte
  output logic [3:0]               m_tuser,   // status
  output logic                     m_tlast    // last_of_run
);

  jsu_pkg::res_group_t grp;
  logic                grp_valid;
  logic [1:0]          idx;
  logic                at_last;

  assign at_last = ({1'b0, idx} == (grp.count - 3'd1));
  // group register can take a new group once its final result leaves
  assign free = !grp_valid || (m_tready && at_last);

  assign m_tvalid = grp_valid;
  assign m_tdata = grp.bytes[idx];
  assign m_tuser = grp.status;
  assign m_tlast = at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      idx <= '0;
    end else if (load && res.count != 3'd0) begin
      grp_valid <= 1'b1;
      idx <= '0;
    end else if (grp_valid && m_tready) begin
      if (at_last) grp_valid <= 1'b0;
      else idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.count != 3'd0) grp <= res;
  end

endmodule

`default_nettype wire

@@ rtl/json_string_unescape_utf8.sv @@
// json string literal decoder: source bytes in, unescaped utf-8 bytes and status out
// input register here; parsing in jsu_decode, result hand-out in jsu_serializer
//
// usage: source text enters on the s_ channel one byte per transaction; s_tuser set
// means the text has ended and s_tdata is ignored. each source byte yields zero to
// four results on the m_ channel: a utf-8 byte (m_tuser 0), a done mark (1) or an
// error code (2..11); m_tlast marks the final result of one source byte.
// whitespace before the opening quote, the quote itself, backslashes and non-final hex
// digits yield nothing. an error returns the parser to waiting for an opening quote.
// a source byte passes through the input register and then the result group register
// before its first result is presented. throughput: one source byte per cycle while
// m_tready stays high and each byte yields at most one result; a byte that expands to
// several utf-8 bytes holds the result register until its last byte is taken, so the
// sustained rate is set by the output side at one result per cycle.
// when m_tready is low the result register holds and the input register fills,
// then s_tready drops. reset clears the parser to idle and empties both registers.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape_utf8 (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // data_byte
  input  wire logic        s_tuser,   // end_of_input
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // out_byte
  output logic [3:0]       m_tuser,   // status
  output logic             m_tlast    // last_of_run
);

  logic                in_valid;
  logic [7:0]          in_byte;
  logic                in_end;
  logic                grp_free;
  logic                dec_fire;
  jsu_pkg::res_group_t res;

  assign dec_fire = in_valid && grp_free;
  assign s_tready = !in_valid || dec_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_end <= s_tuser;
    end
  end

  jsu_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .fire         (dec_fire),
    .data_byte    (in_byte),
    .end_of_input (in_end),
    .res          (res)
  );

  jsu_serializer u_serializer (
    .clk      (clk),
    .rst      (rst),
    .load     (dec_fire),
    .res      (res),
    .free     (grp_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // a status other than a data byte is always a lone, zero-data result
  a_status_alone: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != jsu_pkg::ST_BYTE) |-> (m_tlast && m_tdata == 8'h00))
    else $error("status result not alone or carries data");

  // a held input byte only waits on a pending result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !dec_fire) |-> m_tvalid)
    else $error("input stalled without a pending result");

  // out of reset both registers are empty
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> (!m_tvalid && s_tready))
    else $error("registers not empty after reset");

endmodule

`default_nettype wire

@@ test/json_unescape_checker.sv @@
// json_unescape_checker: watches both stream channels of the json string decoder,
// predicts the decoded utf-8 bytes and status codes, and compares them in order
// depends on jsu_pkg for the status codes, phases and character constants
`timescale 1ns / 1ps

module json_unescape_checker
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,   // data_byte
  input  logic       s_tuser,   // end_of_input
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,   // out_byte
  input  logic [3:0] m_tuser,   // status
  input  logic       m_tlast,   // last_of_run
  output int         mismatches,
  output int         outstanding,
  output int         results_seen,
  output int         strings_closed,
  output int         errors_seen
);

  typedef struct {
    logic [7:0] data;
    status_t    status;
    logic       last;
  } decoded_t;

  decoded_t results_due[$];
  decoded_t got_result;

  // decoder state as the design should hold it
  phase_t      parse_phase;
  logic [15:0] hex_acc;
  logic [2:0]  char_count;
  logic [9:0]  high_bits;
  status_t     held_error;   // ST_BYTE stands for no error held
  int          byte_results;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic clear_parser();
    parse_phase = PH_IDLE;
    hex_acc = '0;
    char_count = '0;
    high_bits = '0;
    held_error = ST_BYTE;
  endtask

  task automatic put_result(input logic [7:0] data, input status_t status);
    decoded_t r;
    r.data = (status == ST_BYTE) ? data : 8'h00;
    r.status = status;
    r.last = 1'b0;
    results_due.insert(results_due.size(), r);
    byte_results++;
  endtask

  task automatic abort_string(input status_t status);
    put_result(8'h00, status);
    clear_parser();
  endtask

  task automatic put_utf8(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      put_result(cp[7:0], ST_BYTE);
    end else if (cp <= 21'h7FF) begin
      put_result({3'b110, cp[10:6]}, ST_BYTE);
      put_result({2'b10, cp[5:0]}, ST_BYTE);
    end else if (cp <= 21'hFFFF) begin
      put_result({4'b1110, cp[15:12]}, ST_BYTE);
      put_result({2'b10, cp[11:6]}, ST_BYTE);
      put_result({2'b10, cp[5:0]}, ST_BYTE);
    end else begin
      put_result({5'b11110, cp[20:18]}, ST_BYTE);
      put_result({2'b10, cp[17:12]}, ST_BYTE);
      put_result({2'b10, cp[11:6]}, ST_BYTE);
      put_result({2'b10, cp[5:0]}, ST_BYTE);
    end
  endtask

  // bit 4 set means the character is not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h10;
    if (c >= "0" && c <= "9") v = c - "0";
    else if (c >= "a" && c <= "f") v = c - "a" + 8'd10;
    else if (c >= "A" && c <= "F") v = c - "A" + 8'd10;
    return v[4:0];
  endfunction

  task automatic take_hex(input logic [7:0] c);
    logic [4:0] d;
    d = hex_value(c);
    if (d[4]) begin
      if (held_error == ST_BYTE) held_error = ST_BAD_HEX;
      d = 5'd0;
    end
    hex_acc = {hex_acc[11:0], d[3:0]};
  endtask

  task automatic decode_source_byte(input logic [7:0] c, input logic eoi);
    logic [20:0] cp;
    decoded_t r;
    byte_results = 0;
    case (parse_phase)
      PH_IDLE: begin
        if (eoi) put_result(8'h00, ST_QUOTE);
        else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) ;
        else if (c == CH_QUOTE) parse_phase = PH_STR;
        else put_result(8'h00, ST_QUOTE);
      end
      PH_STR: begin
        if (eoi) abort_string(ST_UNTERM);
        else if (c == CH_QUOTE) begin
          put_result(8'h00, ST_DONE);
          parse_phase = PH_IDLE;
        end else if (c == CH_BSLASH) parse_phase = PH_ESC;
        else if (c < CH_SPACE) abort_string(ST_CTRL);
        else put_result(c, ST_BYTE);
      end
      PH_ESC: begin
        if (eoi) abort_string(ST_END_ESC);
        else begin
          parse_phase = PH_STR;
          case (c)
            CH_QUOTE, CH_BSLASH, CH_SLASH: put_result(c, ST_BYTE);
            CH_LC_B: put_result(CH_BS, ST_BYTE);
            CH_LC_F: put_result(CH_FF, ST_BYTE);
            CH_LC_N: put_result(CH_LF, ST_BYTE);
            CH_LC_R: put_result(CH_CR, ST_BYTE);
            CH_LC_T: put_result(CH_TAB, ST_BYTE);
            CH_LC_U: begin
              parse_phase = PH_HEX;
              hex_acc = '0;
              char_count = '0;
              held_error = ST_BYTE;
            end
            default: abort_string(ST_BAD_ESC);
          endcase
        end
      end
      PH_HEX: begin
        if (eoi) abort_string(ST_INCOMPLETE);
        else begin
          take_hex(c);
          char_count = char_count + 3'd1;
          if (char_count >= QUAD_CHARS) begin
            if (held_error != ST_BYTE) abort_string(held_error);
            else if (hex_acc >= HIGH_SURR_MIN && hex_acc <= HIGH_SURR_MAX) begin
              high_bits = hex_acc[9:0];
              parse_phase = PH_LOW;
              hex_acc = '0;
              char_count = '0;
            end else if (hex_acc >= LOW_SURR_MIN && hex_acc <= LOW_SURR_MAX) begin
              abort_string(ST_STRAY_LOW);
            end else begin
              put_utf8({5'd0, hex_acc});
              parse_phase = PH_STR;
              hex_acc = '0;
              char_count = '0;
            end
          end
        end
      end
      PH_LOW: begin
        if (eoi) abort_string(ST_MISS_LOW);
        else begin
          // a broken backslash or u overrides a bad hex digit
          if (char_count == 3'd0) begin
            if (c != CH_BSLASH) held_error = ST_MISS_LOW;
          end else if (char_count == 3'd1) begin
            if (c != CH_LC_U) held_error = ST_MISS_LOW;
          end else begin
            take_hex(c);
          end
          char_count = char_count + 3'd1;
          if (char_count >= LOW_ESC_CHARS) begin
            if (held_error != ST_BYTE) abort_string(held_error);
            else if (hex_acc < LOW_SURR_MIN || hex_acc > LOW_SURR_MAX)
              abort_string(ST_BAD_LOW);
            else begin
              cp = SUPP_BASE + {1'b0, high_bits, 10'd0} + {5'd0, hex_acc - LOW_SURR_MIN};
              put_utf8(cp);
              parse_phase = PH_STR;
              hex_acc = '0;
              char_count = '0;
              high_bits = '0;
            end
          end
        end
      end
      default: clear_parser();
    endcase
    if (byte_results > 0) begin
      r = results_due[results_due.size() - 1];
      r.last = 1'b1;
      results_due[results_due.size() - 1] = r;
    end
  endtask

  initial begin
    mismatches = 0;
    outstanding = 0;
    results_seen = 0;
    strings_closed = 0;
    errors_seen = 0;
    clear_parser();
  end

  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      results_due.delete();
    end else begin
      if (s_tvalid && s_tready) decode_source_byte(s_tdata, s_tuser);
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (m_tuser == ST_DONE) strings_closed++;
        else if (m_tuser != ST_BYTE) errors_seen++;
        if (results_due.size() == 0) begin
          report_mismatch("result with none expected, status", m_tuser, 0);
        end else begin
          got_result = results_due.pop_front();
          if (m_tdata !== got_result.data)
            report_mismatch("out_byte", m_tdata, got_result.data);
          if (m_tuser !== got_result.status)
            report_mismatch("status", m_tuser, got_result.status);
          if (m_tlast !== got_result.last)
            report_mismatch("last_of_run", m_tlast, got_result.last);
        end
      end
    end
    outstanding <= results_due.size();
  end

endmodule

@@ test/json_string_unescape_utf8_tb.sv @@
// json_string_unescape_utf8_tb: feeds json string literals, well formed and broken,
// into the decoder with random gaps and stalls; json_unescape_checker judges the output
// depends on jsu_pkg, json_string_unescape_utf8 and json_unescape_checker
`timescale 1ns / 1ps

module json_string_unescape_utf8_tb;
  import jsu_pkg::*;

  localparam int SOURCE_BYTES = 430;
  localparam int STALL_LIMIT = 400;
  localparam int TAIL_CYCLES = 12;

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;   // data_byte
  logic       s_tuser;   // end_of_input
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;   // out_byte
  logic [3:0] m_tuser;   // status
  logic       m_tlast;   // last_of_run

  int mismatches;
  int outstanding;
  int results_seen;
  int strings_closed;
  int errors_seen;

  int bytes_sent;
  int quiet_cycles;
  int rx_stall;
  bit tx_steady;
  bit rx_steady;

  json_string_unescape_utf8 dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  json_unescape_checker decode_check (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .m_tlast        (m_tlast),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .results_seen   (results_seen),
    .strings_closed (strings_closed),
    .errors_seen    (errors_seen)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d cycles without a transaction", STALL_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic bit is_hex(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic bit is_escape_char(input logic [7:0] c);
    return c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH || c == CH_LC_B ||
           c == CH_LC_F || c == CH_LC_N || c == CH_LC_R || c == CH_LC_T || c == CH_LC_U;
  endfunction

  function automatic logic [7:0] simple_escape(input int sel);
    case (sel)
      0: return CH_QUOTE;
      1: return CH_BSLASH;
      2: return CH_SLASH;
      3: return CH_LC_B;
      4: return CH_LC_F;
      5: return CH_LC_N;
      6: return CH_LC_R;
      default: return CH_LC_T;
    endcase
  endfunction

  // letters in random case
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return "0" + v;
    return ($urandom_range(0, 1) ? "a" : "A") + v - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] c;
    do c = $urandom_range(0, 255); while (is_hex(c));
    return c;
  endfunction

  task automatic push_source_byte(input logic [7:0] data, input logic eoi);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= data;
    s_tuser <= eoi;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_char(input logic [7:0] c);
    push_source_byte(c, 1'b0);
  endtask

  // the byte carried with an end of input is don't care, so it is random
  task automatic send_end();
    push_source_byte($urandom_range(0, 255), 1'b1);
  endtask

  task automatic send_quad(input logic [15:0] v, input int bad_at);
    for (int i = 0; i < 4; i++)
      send_char(i == bad_at ? non_hex() : hex_char(v[(3 - i) * 4 +: 4]));
  endtask

  task automatic send_u_escape(input logic [15:0] v, input int bad_at);
    send_char(CH_BSLASH);
    send_char(CH_LC_U);
    send_quad(v, bad_at);
  endtask

  task automatic send_high();
    send_u_escape($urandom_range(16'hD800, 16'hDBFF), -1);
  endtask

  // one broken construct; the decoder is back to idle afterwards
  task automatic send_fault();
    logic [7:0]  c;
    logic [15:0] v;
    int          k;
    bit          b0_ok;
    case ($urandom_range(0, 10))
      0: send_char($urandom_range(0, 8'h1F));
      1: begin
        send_char(CH_BSLASH);
        do c = $urandom_range(0, 255); while (is_escape_char(c));
        send_char(c);
      end
      2: send_u_escape($urandom_range(0, 16'hFFFF), $urandom_range(0, 3));
      3: begin
        send_char(CH_BSLASH);
        send_char(CH_LC_U);
        k = $urandom_range(0, 3);
        for (int i = 0; i < k; i++)
          send_char($urandom_range(0, 3) == 0 ? non_hex() : hex_char($urandom_range(0, 15)));
        send_end();
      end
      4: send_u_escape($urandom_range(16'hDC00, 16'hDFFF), -1);
      5: begin
        send_high();
        do v = $urandom_range(0, 16'hFFFF); while (v >= LOW_SURR_MIN && v <= LOW_SURR_MAX);
        send_u_escape(v, -1);
      end
      6: begin
        // low escape whose backslash or u is wrong, sometimes with a bad digit too
        send_high();
        b0_ok = $urandom_range(0, 1);
        if (b0_ok) begin
          send_char(CH_BSLASH);
          do c = $urandom_range(0, 255); while (c == CH_LC_U);
          send_char(c);
        end else begin
          do c = $urandom_range(0, 255); while (c == CH_BSLASH);
          send_char(c);
          send_char($urandom_range(0, 1) ? CH_LC_U : non_hex());
        end
        send_quad($urandom_range(16'hDC00, 16'hDFFF),
                  $urandom_range(0, 1) ? $urandom_range(0, 3) : -1);
      end
      7: begin
        send_high();
        k = $urandom_range(0, 5);
        v = $urandom_range(16'hDC00, 16'hDFFF);
        for (int i = 0; i < k; i++) begin
          if (i == 0) send_char(CH_BSLASH);
          else if (i == 1) send_char(CH_LC_U);
          else send_char(hex_char(v[(5 - i) * 4 +: 4]));
        end
        send_end();
      end
      8: begin
        send_high();
        send_u_escape($urandom_range(16'hDC00, 16'hDFFF), $urandom_range(0, 3));
      end
      9: begin
        send_char(CH_BSLASH);
        send_end();
      end
      default: send_end();
    endcase
  endtask

  task automatic send_string();
    logic [7:0] c;
    int         k;
    int         segments;
    bit         broken;
    tx_steady = ($urandom_range(0, 4) == 0);
    broken = 1'b0;
    if ($urandom_range(0, 9) == 0) begin
      // stray input before the opening quote
      if ($urandom_range(0, 1)) send_end();
      else begin
        do c = $urandom_range(0, 255);
        while (c == CH_QUOTE || c == CH_SPACE || (c >= CH_TAB && c <= CH_CR));
        send_char(c);
      end
    end
    k = $urandom_range(0, 2);
    for (int i = 0; i < k; i++) begin
      c = $urandom_range(0, 6);
      send_char(c < 5 ? CH_TAB + c : CH_SPACE);
    end
    send_char(CH_QUOTE);
    segments = $urandom_range(0, 6);
    for (int i = 0; i < segments && !broken; i++) begin
      k = $urandom_range(0, 99);
      if (k < 30) begin
        do c = $urandom_range(8'h20, 8'hFF); while (c == CH_QUOTE || c == CH_BSLASH);
        send_char(c);
      end else if (k < 45) begin
        send_char(CH_BSLASH);
        send_char(simple_escape($urandom_range(0, 7)));
      end else if (k < 63) begin
        case ($urandom_range(0, 3))
          0: send_u_escape($urandom_range(0, 16'h7F), -1);
          1: send_u_escape($urandom_range(16'h80, 16'h7FF), -1);
          2: send_u_escape($urandom_range(16'h800, 16'hD7FF), -1);
          default: send_u_escape($urandom_range(16'hE000, 16'hFFFF), -1);
        endcase
      end else if (k < 78) begin
        send_high();
        send_u_escape($urandom_range(16'hDC00, 16'hDFFF), -1);
      end else if (k < 90) begin
        send_fault();
        broken = 1'b1;
      end
    end
    if (!broken) send_char(CH_QUOTE);
  endtask

  initial begin
    m_tready = 1'b0;
    rx_steady = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) rx_steady = !rx_steady;
      rx_stall = rx_steady ? 0 : $urandom_range(0, 3);
      if (rx_stall > 0) begin
        m_tready <= 1'b0;
        repeat (rx_stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'h00;
    s_tuser = 1'b0;
    tx_steady = 1'b0;
    bytes_sent = 0;
    quiet_cycles = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // non-quote byte and end of input while idle, whitespace, open
    send_char(8'hFF);
    send_end();
    send_char(CH_TAB);
    send_char(CH_SPACE);
    send_char(CH_QUOTE);
    // highest code point via a surrogate pair, then code point zero
    send_u_escape(16'hDBFF, -1);
    send_u_escape(16'hDFFF, -1);
    send_u_escape(16'h0000, -1);
    // text runs out inside the string
    send_end();

    while (bytes_sent < SOURCE_BYTES) send_string();
    s_tvalid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d source bytes; checked %0d results", bytes_sent, results_seen);
    $display("%0d strings closed normally, %0d error codes", strings_closed, errors_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d results still expected", mismatches, outstanding);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
